// ===== design/pfdm_pkg.sv =====
// Shared constants and types for the PWM frequency and duty meter.
`default_nettype none

package pfdm_pkg;

    // Default parameter values
    localparam int TIME_WIDTH_DEF    = 32;
    localparam int FRAC_BITS_DEF     = 15;

    // Fixed field widths
    localparam int TS_W              = 32;
    localparam int TOTAL_W           = 32;
    localparam int FREQ_W            = 31;
    localparam int VOL_W             = 16;
    localparam int S_TDATA_W         = 40;
    localparam int M_TDATA_W         = 48;

    // Shared adder width: remainder shifted left plus carry headroom
    localparam int ALU_W             = 34;

    // Item kinds carried in s_tuser
    localparam logic MODE_EDGE       = 1'b0;
    localparam logic MODE_REPORT     = 1'b1;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ACC  = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ===== design/pwm_frequency_duty_meter.sv =====
// PWM frequency and duty-balance meter: edge accumulation and report divider.
//
// Edge transfers (s_tuser = 0) add the time since the previous event to the
// low or high total and count a toggle. A report transfer (s_tuser = 1)
// closes the current interval, adds high and low, and runs a restoring
// division of 2*min(high,low) by the sum, one quotient bit per cycle, for
// VOLUME_FRACTION_BITS+1 steps; a report passes through the accumulate,
// sum, divide and done states before the result is loaded into the output
// register, plus any wait while a prior result is still held there. All of
// these steps share one 34-bit add/subtract unit, and s_tready is high only
// while no item is at work. Time differences wrap modulo 2^TIME_WIDTH;
// totals and the toggle count saturate at 2^32-1. Both result fields are
// zero when the toggle count is 2 or less or the total time is zero.
`default_nettype none

module pwm_frequency_duty_meter #(
    parameter int TIME_WIDTH           = pfdm_pkg::TIME_WIDTH_DEF,
    parameter int VOLUME_FRACTION_BITS = pfdm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pfdm_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] timestamp, [32] pin_level
    input  wire logic                           s_tuser,  // [0] mode
    // Result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pfdm_pkg::M_TDATA_W-1:0]      m_tdata   // [30:0] frequency, [46:31] volume
);

    localparam int TW = TIME_WIDTH;
    localparam int QW = VOLUME_FRACTION_BITS + 1;
    localparam int CW = $clog2(QW + 1);
    localparam int TOT_W = pfdm_pkg::TOTAL_W;
    localparam int AW = pfdm_pkg::ALU_W;
    localparam logic [TOT_W-1:0] TOTAL_MAX = '1;
    localparam logic [pfdm_pkg::VOL_W-1:0] VOL_MAX = '1;
    localparam longint VOL_LIMIT = (VOLUME_FRACTION_BITS >= pfdm_pkg::VOL_W) ?
                                   65535 : (64'd1 << VOLUME_FRACTION_BITS);

    // Control and state registers
    pfdm_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    step_reg, step_next;
    logic             m_valid_reg, m_valid_next;
    logic [TW-1:0]    last_reg, last_next;
    logic             held_reg, held_next;
    logic [TOT_W-1:0] high_reg, high_next;
    logic [TOT_W-1:0] low_reg, low_next;
    logic [TOT_W-1:0] toggle_reg, toggle_next;

    // Working registers
    logic             mode_reg, mode_next;
    logic             pin_reg, pin_next;
    logic [TW-1:0]    dt_reg, dt_next;
    logic [TOT_W:0]   sum_reg, sum_next;
    logic [TOT_W:0]   rem_reg, rem_next;
    logic [QW-1:0]    quot_reg, quot_next;
    logic [pfdm_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Shared add/subtract unit
    logic [AW-1:0]    alu_a, alu_b;
    logic             alu_sub;
    logic [AW:0]      alu_res;

    // Helpers
    logic [TW+TOT_W-1:0]  ts_ext;
    logic [TW+TOT_W-1:0]  dt_ext;
    logic [TOT_W-1:0]     dt_sat;
    logic                 acc_high;
    logic [TOT_W-1:0]     acc_total;
    logic [TOT_W-1:0]     acc_sum;
    logic [TOT_W-1:0]     min_val;
    logic                 div_ge;
    logic [QW+pfdm_pkg::VOL_W-1:0] quot_ext;
    logic [pfdm_pkg::VOL_W-1:0]    vol_sat;
    logic                 report_ok;
    logic                 out_load;
    logic                 s_accept;

    assign s_tready = (state_reg == pfdm_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Widen timestamp and clamp the interval to the total width
    assign ts_ext = {{TW{1'b0}}, s_tdata[pfdm_pkg::TS_W-1:0]};
    assign dt_ext = {{TOT_W{1'b0}}, dt_reg};
    assign dt_sat = (dt_ext[TW+TOT_W-1:TOT_W] != '0) ? TOTAL_MAX : dt_ext[TOT_W-1:0];

    // Pick the total that receives the interval
    assign acc_high  = (mode_reg == pfdm_pkg::MODE_EDGE) ? !pin_reg : held_reg;
    assign acc_total = acc_high ? high_reg : low_reg;
    assign acc_sum   = alu_res[TOT_W] ? TOTAL_MAX : alu_res[TOT_W-1:0];
    assign min_val   = (low_reg > high_reg) ? high_reg : low_reg;
    assign div_ge    = alu_res[AW];

    // Saturate the quotient to the volume field
    assign quot_ext  = {{pfdm_pkg::VOL_W{1'b0}}, quot_reg};
    assign vol_sat   = (quot_ext[QW+pfdm_pkg::VOL_W-1:pfdm_pkg::VOL_W] != '0) ?
                       VOL_MAX : quot_ext[pfdm_pkg::VOL_W-1:0];
    assign report_ok = (toggle_reg > TOT_W'(2)) && (sum_reg != '0);
    assign out_load  = (state_reg == pfdm_pkg::ST_DONE) && (!m_valid_reg || m_tready);

    // Route operands into the shared unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            pfdm_pkg::ST_ACC: begin
                alu_a = AW'(acc_total);
                alu_b = AW'(dt_sat);
            end
            pfdm_pkg::ST_SUM: begin
                alu_a = AW'(high_reg);
                alu_b = AW'(low_reg);
            end
            pfdm_pkg::ST_DIV: begin
                alu_a   = {rem_reg, 1'b0};
                alu_b   = AW'(sum_reg);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
        alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW + 1)'(alu_sub);
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        last_next    = last_reg;
        held_next    = held_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        toggle_next  = toggle_reg;
        mode_next    = mode_reg;
        pin_next     = pin_reg;
        dt_next      = dt_reg;
        sum_next     = sum_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        m_data_next  = m_data_reg;

        // Drop the result once the consumer takes it
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            pfdm_pkg::ST_IDLE: begin
                // Latch the item and measure the interval
                if (s_accept) begin
                    mode_next  = s_tuser;
                    pin_next   = s_tdata[pfdm_pkg::TS_W];
                    dt_next    = ts_ext[TW-1:0] - last_reg;
                    last_next  = ts_ext[TW-1:0];
                    state_next = pfdm_pkg::ST_ACC;
                end
            end
            pfdm_pkg::ST_ACC: begin
                // Add the interval to its total
                if (acc_high) begin
                    high_next = acc_sum;
                end else begin
                    low_next = acc_sum;
                end
                if (mode_reg == pfdm_pkg::MODE_EDGE) begin
                    if (toggle_reg != TOTAL_MAX) begin
                        toggle_next = toggle_reg + TOT_W'(1);
                    end
                    held_next  = pin_reg;
                    state_next = pfdm_pkg::ST_IDLE;
                end else begin
                    state_next = pfdm_pkg::ST_SUM;
                end
            end
            pfdm_pkg::ST_SUM: begin
                // Form the divisor and seed the remainder with the smaller total
                sum_next   = alu_res[TOT_W:0];
                rem_next   = {1'b0, min_val};
                quot_next  = '0;
                step_next  = '0;
                state_next = pfdm_pkg::ST_DIV;
            end
            pfdm_pkg::ST_DIV: begin
                // One restoring division step per cycle
                rem_next  = div_ge ? alu_res[TOT_W:0] : alu_a[TOT_W:0];
                quot_next = {quot_reg[QW-2:0], div_ge};
                step_next = step_reg + CW'(1);
                if (step_reg == CW'(QW - 1)) begin
                    state_next = pfdm_pkg::ST_DONE;
                end
            end
            pfdm_pkg::ST_DONE: begin
                // Load the output register and clear the run totals
                if (out_load) begin
                    m_valid_next = 1'b1;
                    if (report_ok) begin
                        m_data_next = {1'b0, vol_sat, toggle_reg[TOT_W-1:1]};
                    end else begin
                        m_data_next = '0;
                    end
                    high_next   = '0;
                    low_next    = '0;
                    toggle_next = '0;
                    state_next  = pfdm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfdm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pfdm_pkg::ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            last_reg    <= '0;
            held_reg    <= 1'b0;
            high_reg    <= '0;
            low_reg     <= '0;
            toggle_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            last_reg    <= last_next;
            held_reg    <= held_next;
            high_reg    <= high_next;
            low_reg     <= low_next;
            toggle_reg  <= toggle_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        pin_reg    <= pin_next;
        dt_reg     <= dt_next;
        sum_reg    <= sum_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        m_data_reg <= m_data_next;
    end

    // A new result appears only from the final state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == pfdm_pkg::ST_DONE))
        else $error("result raised outside the done state");

    // The volume never exceeds 1.0 or the saturation limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (longint'(m_data_reg[pfdm_pkg::FREQ_W +: pfdm_pkg::VOL_W]) <= VOL_LIMIT))
        else $error("volume above its limit");

    // Loading a result clears the run totals
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (toggle_reg == '0) && (high_reg == '0) && (low_reg == '0))
        else $error("totals not cleared after report");

    // An edge updates the held level to the new pin level
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfdm_pkg::ST_ACC) && (mode_reg == pfdm_pkg::MODE_EDGE)
        |=> held_reg == $past(pin_reg))
        else $error("held level not updated on edge");

endmodule

`default_nettype wire

// ===== bench/pwm_frequency_duty_meter_tb.sv =====
// Self-checking testbench for the PWM frequency and duty meter: table-driven and random streams.
module pwm_frequency_duty_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_TAIL   = 100;
    localparam int DRAIN_CYCLES = 40;
    localparam int TABLE_ROWS   = 25;

    typedef struct packed {
        logic [pfdm_pkg::FREQ_W-1:0] freq;
        logic [pfdm_pkg::VOL_W-1:0]  vol;
    } reading_t;

    // One directed row; typed marks a row whose reading is written in by hand
    typedef struct packed {
        logic                        mode;
        logic [pfdm_pkg::TS_W-1:0]   ts;
        logic                        pin;
        logic                        typed;
        logic [pfdm_pkg::FREQ_W-1:0] freq;
        logic [pfdm_pkg::VOL_W-1:0]  vol;
    } probe_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [pfdm_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [pfdm_pkg::M_TDATA_W-1:0] m_tdata;

    // Meter state as the stimulus side sees it
    logic [pfdm_pkg::TS_W-1:0]    last_stamp;
    logic                         pin_held;
    logic [pfdm_pkg::TOTAL_W-1:0] high_ticks;
    logic [pfdm_pkg::TOTAL_W-1:0] low_ticks;
    logic [pfdm_pkg::TOTAL_W-1:0] toggles;

    reading_t pending_readings[$];
    int       error_count = 0;
    int       sent_count  = 0;
    int       idle_pct    = 25;
    bit       quiet       = 1'b0;

    probe_t probe_table [TABLE_ROWS];

    pwm_frequency_duty_meter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [pfdm_pkg::TOTAL_W-1:0] sat_add(
        logic [pfdm_pkg::TOTAL_W-1:0] a,
        logic [pfdm_pkg::TOTAL_W-1:0] b);
        logic [pfdm_pkg::TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[pfdm_pkg::TOTAL_W] ? '1 : s[pfdm_pkg::TOTAL_W-1:0];
    endfunction

    // Advance the meter by one item; a report yields a reading and clears the totals
    task automatic predict_meter(input logic mode, input logic [pfdm_pkg::TS_W-1:0] ts,
                                 input logic pin,
                                 output bit has_reading, output reading_t reading);
        logic [pfdm_pkg::TS_W-1:0]    dt;
        logic [pfdm_pkg::TOTAL_W:0]   span;
        logic [pfdm_pkg::TOTAL_W-1:0] shorter;
        logic [63:0]                  ratio;
        dt = ts - last_stamp;
        last_stamp = ts;
        has_reading = 1'b0;
        reading = '0;
        if (mode == pfdm_pkg::MODE_EDGE) begin
            // a rising edge closes a low interval, a falling edge a high one
            if (pin)
                low_ticks = sat_add(low_ticks, dt);
            else
                high_ticks = sat_add(high_ticks, dt);
            toggles = sat_add(toggles, 1);
            pin_held = pin;
        end else begin
            if (pin_held)
                high_ticks = sat_add(high_ticks, dt);
            else
                low_ticks = sat_add(low_ticks, dt);
            span = {1'b0, high_ticks} + {1'b0, low_ticks};
            if (toggles > 2 && span != 0) begin
                shorter = (low_ticks > high_ticks) ? high_ticks : low_ticks;
                reading.freq = toggles[pfdm_pkg::TOTAL_W-1:1];
                ratio = ({32'b0, shorter} << (pfdm_pkg::FRAC_BITS_DEF + 1)) / {31'b0, span};
                reading.vol = (ratio > 64'hFFFF) ? 16'hFFFF : ratio[pfdm_pkg::VOL_W-1:0];
            end
            high_ticks = '0;
            low_ticks = '0;
            toggles = '0;
            has_reading = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Present one item at a falling edge, hold it until the transfer, return at a falling edge
    task automatic send_item(input logic mode, input logic [pfdm_pkg::TS_W-1:0] ts,
                             input logic pin,
                             input bit typed, input reading_t typed_reading);
        bit       has_reading;
        reading_t reading;
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(pfdm_pkg::S_TDATA_W - pfdm_pkg::TS_W - 1){1'b0}}, pin, ts};
        do @(posedge aclk); while (!s_tready);
        predict_meter(mode, ts, pin, has_reading, reading);
        if (has_reading)
            pending_readings.push_back(typed ? typed_reading : reading);
        sent_count++;
        @(negedge aclk);
    endtask

    function automatic logic [pfdm_pkg::TS_W-1:0] pick_gap();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom;
            2, 3:    return $urandom_range(1, 15);
            default: return $urandom_range(1, 2000);
        endcase
    endfunction

    // Receiver: hold tready low in bursts, none in the tail of the run
    initial begin
        int stall_left;
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer against the oldest pending reading
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'h0);
            end else begin
                want = pending_readings.pop_front();
                if (m_tdata[30:0] !== want.freq)
                    report_mismatch("frequency", {1'b0, m_tdata[30:0]}, {1'b0, want.freq});
                if (m_tdata[46:31] !== want.vol)
                    report_mismatch("volume", {16'b0, m_tdata[46:31]}, {16'b0, want.vol});
            end
        end
    end

    initial begin
        #5ms;
        $display("** pwm_frequency_duty_meter: FAILED **");
        $finish;
    end

    initial begin
        int                        k;
        int                        row;
        logic [pfdm_pkg::TS_W-1:0] now;
        logic                      lvl;
        reading_t                  typed_reading;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = pfdm_pkg::MODE_EDGE;
        s_tdata  = '0;
        last_stamp = '0;
        pin_held   = 1'b0;
        high_ticks = '0;
        low_ticks  = '0;
        toggles    = '0;

        probe_table = '{
            // report straight after reset: nothing measured
            '{pfdm_pkg::MODE_REPORT, 32'd0,         1'b0, 1'b1, 31'd0, 16'd0},
            // only two toggles
            '{pfdm_pkg::MODE_EDGE,   32'd100,       1'b1, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_EDGE,   32'd150,       1'b0, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_REPORT, 32'd200,       1'b1, 1'b1, 31'd0, 16'd0},
            // three toggles, but no time has passed
            '{pfdm_pkg::MODE_EDGE,   32'd200,       1'b1, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_EDGE,   32'd200,       1'b0, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_EDGE,   32'd200,       1'b1, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_REPORT, 32'd200,       1'b0, 1'b1, 31'd0, 16'd0},
            // timestamps wrap through zero
            '{pfdm_pkg::MODE_EDGE,   32'hFFFF_FFF0, 1'b0, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_EDGE,   32'h0000_0010, 1'b1, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_EDGE,   32'h0000_0030, 1'b0, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_REPORT, 32'h0000_0050, 1'b0, 1'b0, 31'd0, 16'd0},
            // maximal gaps saturate both totals: perfect balance
            '{pfdm_pkg::MODE_EDGE,   32'h0000_004F, 1'b0, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_EDGE,   32'h0000_004E, 1'b0, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_EDGE,   32'h0000_004D, 1'b1, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_REPORT, 32'h0000_004D, 1'b0, 1'b1, 31'd1, 16'd32768},
            // pin never seen low: zero balance
            '{pfdm_pkg::MODE_EDGE,   32'h0000_0060, 1'b0, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_EDGE,   32'h0000_0070, 1'b0, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_EDGE,   32'h0000_0080, 1'b0, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_REPORT, 32'h0000_0080, 1'b1, 1'b1, 31'd1, 16'd0},
            // an ordinary square wave
            '{pfdm_pkg::MODE_EDGE,   32'h0000_0090, 1'b1, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_EDGE,   32'h0000_00A0, 1'b0, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_EDGE,   32'h0000_00B0, 1'b1, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_EDGE,   32'h0000_00C5, 1'b0, 1'b0, 31'd0, 16'd0},
            '{pfdm_pkg::MODE_REPORT, 32'h0000_00D0, 1'b0, 1'b0, 31'd0, 16'd0}
        };

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed table
        for (row = 0; row < TABLE_ROWS; row++) begin
            typed_reading.freq = probe_table[row].freq;
            typed_reading.vol  = probe_table[row].vol;
            send_item(probe_table[row].mode, probe_table[row].ts, probe_table[row].pin,
                      probe_table[row].typed, typed_reading);
        end

        // Drop valid and wait for every pending reading before going random
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        @(negedge aclk);

        // Random part: mostly edge trains closed by a report, some noise items
        now = $urandom;
        typed_reading = '0;
        sent_count = 0;
        while (sent_count < RANDOM_ITEMS) begin
            if (sent_count % 100 == 0)
                idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
            quiet = (sent_count >= RANDOM_ITEMS - QUIET_TAIL);
            if ($urandom_range(0, 9) == 0) begin
                send_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)), 1'b0,
                          typed_reading);
            end else begin
                k = $urandom_range(0, 9);
                lvl = 1'($urandom_range(0, 1));
                repeat (k) begin
                    // mostly alternate, sometimes repeat the level
                    if ($urandom_range(0, 5) != 0)
                        lvl = ~lvl;
                    now = now + pick_gap();
                    send_item(pfdm_pkg::MODE_EDGE, now, lvl, 1'b0, typed_reading);
                end
                // a few trains are left open and run into the next one
                if ($urandom_range(0, 7) != 0) begin
                    now = now + pick_gap();
                    send_item(pfdm_pkg::MODE_REPORT, now, 1'($urandom_range(0, 1)), 1'b0,
                              typed_reading);
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain the remaining readings, then idle before the verdict
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("** pwm_frequency_duty_meter: PASSED **");
        else
            $display("** pwm_frequency_duty_meter: FAILED **");
        $finish;
    end

endmodule
